[src/bez_pkg.sv]
`timescale 1ns / 1ps

package bez_pkg;

  localparam int unsigned CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_POINT_START  = 3'd0,
    CFG_POINT_CTRL_A = 3'd1,
    CFG_POINT_CTRL_B = 3'd2,
    CFG_POINT_END    = 3'd3
  } cfg_idx_t;

  // load enables of the six pipeline stages, s1 nearest the input
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } bez_adv_t;

endpackage

[src/bez_in_if.sv]
`timescale 1ns / 1ps

interface bez_in_if #(
  parameter int unsigned PARAM_FRAC_BITS = 16
);
  logic                     valid;
  logic                     ready;
  logic [PARAM_FRAC_BITS:0] curve_param;

  modport source (output valid, output curve_param, input ready);
  modport sink (input valid, input curve_param, output ready);
endinterface

[src/bez_out_if.sv]
`timescale 1ns / 1ps

interface bez_out_if #(
  parameter int unsigned COORD_BITS = 21
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic signed [COORD_BITS-1:0] pos_z;
  logic signed [COORD_BITS+2:0] vel_x;
  logic signed [COORD_BITS+2:0] vel_y;
  logic signed [COORD_BITS+2:0] vel_z;

  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  output vel_x, output vel_y, output vel_z, input ready);
  modport sink (input valid, input pos_x, input pos_y, input pos_z,
                input vel_x, input vel_y, input vel_z, output ready);
endinterface

[src/bez_wgt.sv]
`timescale 1ns / 1ps

module bez_wgt import bez_pkg::*; #(
  parameter int unsigned PARAM_FRAC_BITS = 16
) (
  input  logic                       clk,
  input  bez_adv_t                   adv,
  input  logic [PARAM_FRAC_BITS:0]   curve_param,
  output logic [PARAM_FRAC_BITS:0]   w0,
  output logic [PARAM_FRAC_BITS+1:0] w1,
  output logic [PARAM_FRAC_BITS+1:0] w2,
  output logic [PARAM_FRAC_BITS:0]   w3,
  output logic [PARAM_FRAC_BITS:0]   uu,
  output logic [PARAM_FRAC_BITS:0]   ut,
  output logic [PARAM_FRAC_BITS:0]   tt
);

  localparam int unsigned F  = PARAM_FRAC_BITS;
  localparam int unsigned PW = F + 1;
  localparam int unsigned MW = 2 * PW;
  localparam logic [PW-1:0] ONE  = PW'(1) << F;
  localparam logic [MW-1:0] HALF = MW'(1) << (F - 1);
  localparam logic [PW-1:0] ZPAD = '0;

  // stage 1: clamped parameter and its complement
  logic [PW-1:0] t1_r, u1_r, t1_nxt, u1_nxt;
  // stage 2: rounded squares and cross term
  logic [PW-1:0] uu2_r, tt2_r, ut2_r, t2_r, u2_r;
  logic [PW-1:0] uu2_nxt, tt2_nxt, ut2_nxt;
  logic [MW-1:0] m_uu, m_tt, m_ut;
  // stage 3: Bernstein weights
  logic [MW-1:0] m_w0, m_w1, m_w2, m_w3;
  logic [PW-1:0] r1, r2;
  logic [PW-1:0] w0_r, w3_r, uu3_r, ut3_r, tt3_r;
  logic [PW:0]   w1_r, w2_r, w1_nxt, w2_nxt;

  always_comb begin
    t1_nxt = (curve_param > ONE) ? ONE : curve_param;
    u1_nxt = ONE - t1_nxt;
  end

  always_comb begin
    m_uu    = {ZPAD, u1_r} * {ZPAD, u1_r} + HALF;
    m_tt    = {ZPAD, t1_r} * {ZPAD, t1_r} + HALF;
    m_ut    = {ZPAD, u1_r} * {ZPAD, t1_r} + HALF;
    uu2_nxt = m_uu[F +: PW];
    tt2_nxt = m_tt[F +: PW];
    ut2_nxt = m_ut[F +: PW];
  end

  always_comb begin
    m_w0   = {ZPAD, uu2_r} * {ZPAD, u2_r} + HALF;
    m_w1   = {ZPAD, uu2_r} * {ZPAD, t2_r} + HALF;
    m_w2   = {ZPAD, tt2_r} * {ZPAD, u2_r} + HALF;
    m_w3   = {ZPAD, tt2_r} * {ZPAD, t2_r} + HALF;
    r1     = m_w1[F +: PW];
    r2     = m_w2[F +: PW];
    // inner weights carry the factor of three
    w1_nxt = {1'b0, r1} + {r1, 1'b0};
    w2_nxt = {1'b0, r2} + {r2, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      t1_r <= t1_nxt;
      u1_r <= u1_nxt;
    end
    if (adv.s2) begin
      uu2_r <= uu2_nxt;
      tt2_r <= tt2_nxt;
      ut2_r <= ut2_nxt;
      t2_r  <= t1_r;
      u2_r  <= u1_r;
    end
    if (adv.s3) begin
      w0_r  <= m_w0[F +: PW];
      w1_r  <= w1_nxt;
      w2_r  <= w2_nxt;
      w3_r  <= m_w3[F +: PW];
      uu3_r <= uu2_r;
      ut3_r <= ut2_r;
      tt3_r <= tt2_r;
    end
  end

  assign w0 = w0_r;
  assign w1 = w1_r;
  assign w2 = w2_r;
  assign w3 = w3_r;
  assign uu = uu3_r;
  assign ut = ut3_r;
  assign tt = tt3_r;

endmodule

[src/bez_axis.sv]
`timescale 1ns / 1ps

module bez_axis import bez_pkg::*; #(
  parameter int unsigned COORD_BITS      = 21,
  parameter int unsigned PARAM_FRAC_BITS = 16
) (
  input  logic                         clk,
  input  bez_adv_t                     adv,
  input  logic signed [COORD_BITS-1:0] c0,
  input  logic signed [COORD_BITS-1:0] c1,
  input  logic signed [COORD_BITS-1:0] c2,
  input  logic signed [COORD_BITS-1:0] c3,
  input  logic [PARAM_FRAC_BITS:0]     w0,
  input  logic [PARAM_FRAC_BITS+1:0]   w1,
  input  logic [PARAM_FRAC_BITS+1:0]   w2,
  input  logic [PARAM_FRAC_BITS:0]     w3,
  input  logic [PARAM_FRAC_BITS:0]     uu,
  input  logic [PARAM_FRAC_BITS:0]     ut,
  input  logic [PARAM_FRAC_BITS:0]     tt,
  output logic signed [COORD_BITS-1:0] pos,
  output logic signed [COORD_BITS+2:0] vel
);

  localparam int unsigned F   = PARAM_FRAC_BITS;
  localparam int unsigned C   = COORD_BITS;
  localparam int unsigned PPW = F + C + 3;
  localparam int unsigned VPW = F + C + 3;
  localparam int unsigned PSW = F + C + 5;
  localparam int unsigned VSW = F + C + 7;
  localparam logic signed [PSW-1:0] PS_HALF = PSW'(2 ** (F - 1));
  localparam logic signed [VSW-1:0] VS_HALF = VSW'(2 ** (F - 1));
  localparam logic signed [PSW-1:0] POS_HI  = PSW'(2 ** (C - 1) - 1);
  localparam logic signed [PSW-1:0] POS_LO  = PSW'(-(2 ** (C - 1)));
  localparam logic signed [VSW-1:0] VEL_HI  = VSW'(2 ** (C + 2) - 1);
  localparam logic signed [VSW-1:0] VEL_LO  = VSW'(-(2 ** (C + 2)));

  // stage 4: weighted points and weighted point differences
  logic signed [C:0]     d10, d21, d32;
  logic signed [PPW-1:0] pp0_r, pp1_r, pp2_r, pp3_r;
  logic signed [PPW-1:0] pp0_nxt, pp1_nxt, pp2_nxt, pp3_nxt;
  logic signed [VPW-1:0] vp0_r, vp1_r, vp2_r;
  logic signed [VPW-1:0] vp0_nxt, vp1_nxt, vp2_nxt;
  // stage 5: sums
  logic signed [PSW-1:0] ps_r, ps_nxt;
  logic signed [VSW-1:0] vs_r, vs_nxt;
  // stage 6: rounded and saturated result
  logic signed [VSW-1:0] vs3;
  logic signed [PSW-1:0] pr;
  logic signed [VSW-1:0] vr;
  logic signed [C-1:0]   pos_r, pos_nxt;
  logic signed [C+2:0]   vel_r, vel_nxt;

  always_comb begin
    d10     = $signed({c1[C-1], c1}) - $signed({c0[C-1], c0});
    d21     = $signed({c2[C-1], c2}) - $signed({c1[C-1], c1});
    d32     = $signed({c3[C-1], c3}) - $signed({c2[C-1], c2});
    pp0_nxt = $signed({2'b00, w0}) * c0;
    pp1_nxt = $signed({1'b0, w1}) * c1;
    pp2_nxt = $signed({1'b0, w2}) * c2;
    pp3_nxt = $signed({2'b00, w3}) * c3;
    vp0_nxt = $signed({1'b0, uu}) * d10;
    vp1_nxt = $signed({1'b0, ut}) * d21;
    vp2_nxt = $signed({1'b0, tt}) * d32;
  end

  always_comb begin
    ps_nxt = PSW'(pp0_r) + PSW'(pp1_r) + PSW'(pp2_r) + PSW'(pp3_r);
    vs_nxt = VSW'(vp0_r) + (VSW'(vp1_r) <<< 1) + VSW'(vp2_r);
  end

  always_comb begin
    vs3 = vs_r + (vs_r <<< 1);
    pr  = (ps_r + PS_HALF) >>> F;
    vr  = (vs3 + VS_HALF) >>> F;
    priority if (pr > POS_HI) begin
      pos_nxt = $signed(POS_HI[C-1:0]);
    end else if (pr < POS_LO) begin
      pos_nxt = $signed(POS_LO[C-1:0]);
    end else begin
      pos_nxt = $signed(pr[C-1:0]);
    end
    priority if (vr > VEL_HI) begin
      vel_nxt = $signed(VEL_HI[C+2:0]);
    end else if (vr < VEL_LO) begin
      vel_nxt = $signed(VEL_LO[C+2:0]);
    end else begin
      vel_nxt = $signed(vr[C+2:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s4) begin
      pp0_r <= pp0_nxt;
      pp1_r <= pp1_nxt;
      pp2_r <= pp2_nxt;
      pp3_r <= pp3_nxt;
      vp0_r <= vp0_nxt;
      vp1_r <= vp1_nxt;
      vp2_r <= vp2_nxt;
    end
    if (adv.s5) begin
      ps_r <= ps_nxt;
      vs_r <= vs_nxt;
    end
    if (adv.s6) begin
      pos_r <= pos_nxt;
      vel_r <= vel_nxt;
    end
  end

  assign pos = pos_r;
  assign vel = vel_r;

endmodule

[src/cubic_bezier_point_evaluator.sv]
`timescale 1ns / 1ps
// Channel   Dir  Handshake       Payload
// in_ch     in   valid / ready   curve_param (unsigned Q1.F, clamped to 1.0)
// out_ch    out  valid / ready   pos_x/y/z, vel_x/y/z (signed, saturated)
// cfg_*     in   cfg_we          cfg_index, cfg_data (packed control point)
//
// One item per cycle sustained while the output is not stalled. There are six
// register stages: clamp, squares, weights, multiplies, sums, round/saturate.
// The first stage loads at the accepting edge.
// Reset clears the stage valid bits and the four control points.
// A stalled output holds the stages behind it only as far as they are full;
// empty stages keep filling, so nothing is dropped or repeated.

module cubic_bezier_point_evaluator import bez_pkg::*; #(
  parameter int unsigned COORD_BITS      = 21,
  parameter int unsigned PARAM_FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  bez_in_if.sink                      in_ch,
  bez_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [3*COORD_BITS-1:0]     cfg_data
);

  localparam int unsigned C          = COORD_BITS;
  localparam int unsigned F          = PARAM_FRAC_BITS;
  localparam int unsigned NUM_POINTS = 4;
  localparam int unsigned STAGES     = 6;

  logic [3*C-1:0]    pt_r [NUM_POINTS];
  logic [STAGES-1:0] v_r;
  logic [STAGES-1:0] adv_v;
  bez_adv_t          adv;

  logic [F:0]   w0, w3, uu, ut, tt;
  logic [F+1:0] w1, w2;

  logic signed [C-1:0] pos_a [3];
  logic signed [C+2:0] vel_a [3];

  // a stage loads when it is empty or the stage after it moves on
  always_comb begin
    adv_v[STAGES-1] = !v_r[STAGES-1] || out_ch.ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      adv_v[k] = !v_r[k] || adv_v[k+1];
    end
  end

  assign adv.s1 = adv_v[0];
  assign adv.s2 = adv_v[1];
  assign adv.s3 = adv_v[2];
  assign adv.s4 = adv_v[3];
  assign adv.s5 = adv_v[4];
  assign adv.s6 = adv_v[5];

  assign in_ch.ready  = adv_v[0];
  assign out_ch.valid = v_r[STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv_v[0]) begin
        v_r[0] <= in_ch.valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (adv_v[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_POINTS; i++) begin
        pt_r[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_POINT_START:  pt_r[0] <= cfg_data;
        CFG_POINT_CTRL_A: pt_r[1] <= cfg_data;
        CFG_POINT_CTRL_B: pt_r[2] <= cfg_data;
        CFG_POINT_END:    pt_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  bez_wgt #(
    .PARAM_FRAC_BITS(F)
  ) u_wgt (
    .clk         (clk),
    .adv         (adv),
    .curve_param (in_ch.curve_param),
    .w0          (w0),
    .w1          (w1),
    .w2          (w2),
    .w3          (w3),
    .uu          (uu),
    .ut          (ut),
    .tt          (tt)
  );

  for (genvar a = 0; a < 3; a++) begin : g_axis
    bez_axis #(
      .COORD_BITS      (C),
      .PARAM_FRAC_BITS (F)
    ) u_axis (
      .clk (clk),
      .adv (adv),
      .c0  ($signed(pt_r[0][a*C +: C])),
      .c1  ($signed(pt_r[1][a*C +: C])),
      .c2  ($signed(pt_r[2][a*C +: C])),
      .c3  ($signed(pt_r[3][a*C +: C])),
      .w0  (w0),
      .w1  (w1),
      .w2  (w2),
      .w3  (w3),
      .uu  (uu),
      .ut  (ut),
      .tt  (tt),
      .pos (pos_a[a]),
      .vel (vel_a[a])
    );
  end

  assign out_ch.pos_x = pos_a[0];
  assign out_ch.pos_y = pos_a[1];
  assign out_ch.pos_z = pos_a[2];
  assign out_ch.vel_x = vel_a[0];
  assign out_ch.vel_y = vel_a[1];
  assign out_ch.vel_z = vel_a[2];

  // input backs up only when every stage is full and the output is stalled
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (&v_r && !out_ch.ready))
    else $error("input stalled with an empty stage");

  // a result appears only out of a filled sum stage
  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(v_r[STAGES-1]) |-> $past(v_r[STAGES-2]))
    else $error("result appeared without an item behind it");

  // a held sum stage keeps its item
  a_hold_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[STAGES-2] && !adv_v[STAGES-2]) |=> v_r[STAGES-2])
    else $error("stalled item lost in sum stage");

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

import bez_pkg::*;

typedef struct packed {
  logic signed [20:0] pos_x;
  logic signed [20:0] pos_y;
  logic signed [20:0] pos_z;
  logic signed [23:0] vel_x;
  logic signed [23:0] vel_y;
  logic signed [23:0] vel_z;
} bez_point_t;

typedef enum int {
  PTS_RANDOM,
  PTS_MAX,
  PTS_MIN,
  PTS_ZIGZAG,
  PTS_ZERO,
  PTS_NEAR
} point_style_t;

class bezier_ledger;
  localparam int COORD = 21;
  localparam int FRAC = 16;
  localparam int NUM_POINTS = 4;
  localparam longint unsigned ONE = 64'd1 << FRAC;
  localparam longint unsigned HALF = 64'd1 << (FRAC - 1);
  localparam int BERN = 3;

  logic [3*COORD-1:0] points [NUM_POINTS];
  bez_point_t         pending_points [$];
  int                 mismatches;

  function new();
    foreach (points[i]) points[i] = '0;
    mismatches = 0;
  endfunction

  function void set_point(int idx, logic [3*COORD-1:0] v);
    if (idx < NUM_POINTS) points[idx] = v;
  endfunction

  function int pending();
    return pending_points.size();
  endfunction

  function longint unsigned rnd_u(longint unsigned p);
    return (p + HALF) >> FRAC;
  endfunction

  // floor division keeps round half up for negative sums too
  function longint rnd_s(longint v);
    return (v + longint'(HALF)) >>> FRAC;
  endfunction

  function longint clip(longint v, int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) << (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function bez_point_t eval_curve(logic [FRAC:0] k);
    longint unsigned t, u, uu, tt, ut;
    longint w [4];
    longint c [4];
    longint ps, vs;
    longint pos [3];
    longint vel [3];
    bez_point_t r;
    t = k;
    if (t > ONE) t = ONE;
    u = ONE - t;
    uu = rnd_u(u * u);
    tt = rnd_u(t * t);
    ut = rnd_u(u * t);
    w[0] = rnd_u(uu * u);
    w[1] = BERN * rnd_u(uu * t);
    w[2] = BERN * rnd_u(tt * u);
    w[3] = rnd_u(tt * t);
    for (int axis = 0; axis < 3; axis++) begin
      ps = 0;
      for (int i = 0; i < NUM_POINTS; i++) begin
        c[i] = $signed(points[i][axis*COORD +: COORD]);
        ps += w[i] * c[i];
      end
      vs = longint'(uu) * (c[1] - c[0]) + 2 * longint'(ut) * (c[2] - c[1])
         + longint'(tt) * (c[3] - c[2]);
      pos[axis] = clip(rnd_s(ps), COORD);
      vel[axis] = clip(rnd_s(BERN * vs), COORD + 3);
    end
    r.pos_x = pos[0][20:0];
    r.pos_y = pos[1][20:0];
    r.pos_z = pos[2][20:0];
    r.vel_x = vel[0][23:0];
    r.vel_y = vel[1][23:0];
    r.vel_z = vel[2][23:0];
    return r;
  endfunction

  function void note_param(logic [FRAC:0] k);
    pending_points.push_back(eval_curve(k));
  endfunction

  function void cmp_field(string name, longint exp_v, longint got_v);
    if (exp_v != got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  function void check_point(bez_point_t got);
    bez_point_t exp_p;
    if (pending_points.size() == 0) begin
      $error("result with no item outstanding: pos %0d %0d %0d", got.pos_x, got.pos_y,
             got.pos_z);
      mismatches++;
      return;
    end
    exp_p = pending_points.pop_front();
    cmp_field("pos_x", exp_p.pos_x, got.pos_x);
    cmp_field("pos_y", exp_p.pos_y, got.pos_y);
    cmp_field("pos_z", exp_p.pos_z, got.pos_z);
    cmp_field("vel_x", exp_p.vel_x, got.vel_x);
    cmp_field("vel_y", exp_p.vel_y, got.vel_y);
    cmp_field("vel_z", exp_p.vel_z, got.vel_z);
  endfunction
endclass

module testbench;
  localparam int COORD_BITS = 21;
  localparam int PARAM_FRAC_BITS = 16;
  localparam int PARAM_W = PARAM_FRAC_BITS + 1;
  localparam int NUM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 206;
  localparam int IDLE_PCT = 69;
  localparam int BOTH_IDLE_PCT = 33;
  localparam int DRAIN_CYCLES = 12;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [PARAM_FRAC_BITS:0] PARAM_ONE = 17'h10000;
  localparam logic [PARAM_FRAC_BITS:0] PARAM_ALL = 17'h1FFFF;
  localparam logic [COORD_BITS-1:0] COORD_MAX = 21'h0FFFFF;
  localparam logic [COORD_BITS-1:0] COORD_MIN = 21'h100000;

  localparam logic [PARAM_FRAC_BITS:0] EDGE_PARAMS [16] = '{
    17'h00000, 17'h00001, 17'h00002, 17'h04000, 17'h08000, 17'h0C000,
    17'h0FFFF, 17'h10000, 17'h10001, 17'h18000, 17'h1FFFF, 17'h15555,
    17'h0AAAA, 17'h00100, 17'h0FF00, 17'h12345
  };

  localparam point_style_t PHASE_STYLE [NUM_PHASES] = '{
    PTS_ZIGZAG, PTS_MAX, PTS_MIN, PTS_RANDOM, PTS_ZERO, PTS_NEAR, PTS_RANDOM, PTS_RANDOM
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [3*COORD_BITS-1:0] cfg_data;
  logic sender_idles;
  logic recv_stalls;
  int   idle_pct = IDLE_PCT;
  int   quiet_cycles = 0;

  bezier_ledger sb;

  bez_in_if #(.PARAM_FRAC_BITS(PARAM_FRAC_BITS)) in_ch ();
  bez_out_if #(.COORD_BITS(COORD_BITS)) out_ch ();

  cubic_bezier_point_evaluator #(
    .COORD_BITS(COORD_BITS),
    .PARAM_FRAC_BITS(PARAM_FRAC_BITS)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= !(recv_stalls && ($urandom_range(99) < idle_pct));
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.note_param(in_ch.curve_param);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_point('{out_ch.pos_x, out_ch.pos_y, out_ch.pos_z,
                       out_ch.vel_x, out_ch.vel_y, out_ch.vel_z});
    end
  end

  // count cycles with no item moving on either side
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [PARAM_FRAC_BITS:0] rand_param();
    int pick;
    pick = $urandom_range(99);
    if (pick < 80) return PARAM_W'($urandom_range(PARAM_ONE));
    if (pick < 90) return PARAM_W'($urandom_range(PARAM_ALL, PARAM_ONE + 1));
    case ($urandom_range(3))
      0: return '0;
      1: return 17'h00001;
      2: return PARAM_ONE - 1;
      default: return PARAM_ONE;
    endcase
  endfunction

  function automatic logic [3*COORD_BITS-1:0] pick_point(point_style_t style, int idx);
    logic [63:0] raw;
    logic [COORD_BITS-1:0] x, y, z;
    raw = {$urandom(), $urandom()};
    case (style)
      PTS_MAX:    return {COORD_MAX, COORD_MAX, COORD_MAX};
      PTS_MIN:    return {COORD_MIN, COORD_MIN, COORD_MIN};
      PTS_ZERO:   return '0;
      PTS_ZIGZAG: begin
        // alternate the extremes to swing the tangent as far as it goes
        if (idx % 2 == 0) return {COORD_MAX, COORD_MIN, COORD_MIN};
        return {COORD_MIN, COORD_MAX, COORD_MAX};
      end
      PTS_NEAR: begin
        x = COORD_BITS'($urandom_range(2000) - 1000);
        y = COORD_BITS'($urandom_range(2000) - 1000);
        z = COORD_BITS'($urandom_range(2000) - 1000);
        return {z, y, x};
      end
      default: return raw[3*COORD_BITS-1:0];
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [3*COORD_BITS-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    sb.set_point(int'(idx), v);
    @(posedge clk);
  endtask

  task automatic load_points(input point_style_t style);
    logic [63:0] junk;
    write_reg(CFG_POINT_START, pick_point(style, 0));
    write_reg(CFG_POINT_CTRL_A, pick_point(style, 1));
    write_reg(CFG_POINT_CTRL_B, pick_point(style, 2));
    write_reg(CFG_POINT_END, pick_point(style, 3));
    // indexes past the point list must leave the points alone
    for (int i = int'(CFG_POINT_END) + 1; i < 2**CFG_IDX_BITS; i++) begin
      junk = {$urandom(), $urandom()};
      write_reg(CFG_IDX_BITS'(i), junk[3*COORD_BITS-1:0]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_param(input logic [PARAM_FRAC_BITS:0] k);
    if (sender_idles) begin
      while ($urandom_range(99) < idle_pct) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid       <= 1'b1;
    in_ch.curve_param <= k;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // step to a clock edge first so the last accepted item is already noted
  task automatic drain();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    sb = new();
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_POINT_START;
    cfg_data          <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.curve_param <= '0;
    sender_idles      = 1'b0;
    recv_stalls       = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      load_points(PHASE_STYLE[ph]);
      sender_idles = (ph % 4 == 1) || (ph % 4 == 3);
      recv_stalls  = (ph % 4 == 2) || (ph % 4 == 3);
      idle_pct     = (ph % 4 == 3) ? BOTH_IDLE_PCT : IDLE_PCT;
      if (ph == 0) begin
        foreach (EDGE_PARAMS[i]) send_param(EDGE_PARAMS[i]);
      end
      repeat (ITEMS_PER_PHASE) send_param(rand_param());
      in_ch.valid <= 1'b0;
    end

    drain();
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
